// File: rtl/core/lzc_pkg.sv
// ----------------------------------------------------------------------------
// lzc_pkg
// Shared constants and the position hash for the LZ block compressor.
// ----------------------------------------------------------------------------
package lzc_pkg;

    localparam int HASH_ENTRIES = 256;
    localparam int HASH_W       = 8;
    localparam int DIST_W       = 17;
    localparam int MAX_DIST     = 131000;
    localparam int MIN_MATCH    = 4;

    localparam logic [7:0] TOK_LONG_RUN  = 8'h3F;
    localparam logic [7:0] TOK_SHORT_RUN = 8'h07;
    localparam logic [7:0] TOK_TAIL      = 8'h1F;

    function automatic logic [HASH_W-1:0] lzc_hash(input logic [31:0] v);
        logic [31:0] m;
        m = v ^ (v >> 7) ^ (v >> 17);
        return m[HASH_W-1:0];
    endfunction

endpackage

// File: rtl/core/lzc_store.sv
// ----------------------------------------------------------------------------
// lzc_store
// Block byte store: one write port, two registered read ports. Reads at or
// past the fill limit return zero.
// ----------------------------------------------------------------------------
module lzc_store #(
    parameter int DEPTH = 131072,
    parameter int PW    = 18,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [PW-1:0] i_limit,
    input  logic [PW-1:0] i_raddr_a,
    input  logic [PW-1:0] i_raddr_b,
    output logic [7:0]    o_rdata_a,
    output logic [7:0]    o_rdata_b
);

    logic [7:0] mem [DEPTH];
    logic [7:0] r_q_a;
    logic [7:0] r_q_b;
    logic       r_in_a;
    logic       r_in_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_q_a  <= mem[i_raddr_a[AW-1:0]];
        r_q_b  <= mem[i_raddr_b[AW-1:0]];
        r_in_a <= i_raddr_a < i_limit;
        r_in_b <= i_raddr_b < i_limit;
    end

    assign o_rdata_a = r_in_a ? r_q_a : 8'd0;
    assign o_rdata_b = r_in_b ? r_q_b : 8'd0;

endmodule

// File: rtl/core/lz_block_compressor.sv
// ----------------------------------------------------------------------------
// lz_block_compressor
// Single-hash LZ77 block compressor: load beats fill the block store, pull
// beats return the compressed stream one byte per beat.
// ----------------------------------------------------------------------------
// A pull beat returns a token or literal byte after any refill work: scanning
// positions, comparing bytes through the block store read ports, and a hash
// insert for each byte of an accepted match.
// Reset (sync, active low) clears control, counts and hash valid bits; the
// block store holds no reset.
// ----------------------------------------------------------------------------
module lz_block_compressor
    import lzc_pkg::*;
#(
    parameter int BLOCK_BYTES = 131072,
    parameter int MAX_MATCH   = 514
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // data_byte
    input  logic       i_s_axis_tlast,   // end_of_block
    input  logic [0:0] i_s_axis_tuser,   // func
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // out_byte
    output logic       o_m_axis_tlast,   // out_last
    output logic [1:0] o_m_axis_tuser    // block_overflow, out_valid
);

    localparam int AW = $clog2(BLOCK_BYTES);
    localparam int PW = $clog2(BLOCK_BYTES + 4);
    localparam int LW = $clog2(MAX_MATCH + 1);

    localparam logic [2:0] PH_LOAD = 3'd0;
    localparam logic [2:0] PH_SCAN = 3'd1;
    localparam logic [2:0] PH_LITS = 3'd2;
    localparam logic [2:0] PH_TAIL = 3'd3;
    localparam logic [2:0] PH_TERM = 3'd4;
    localparam logic [2:0] PH_DONE = 3'd5;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_REFILL = 4'd1;
    localparam logic [3:0] S_H0     = 4'd2;
    localparam logic [3:0] S_H1     = 4'd3;
    localparam logic [3:0] S_H2     = 4'd4;
    localparam logic [3:0] S_HDQ    = 4'd5;
    localparam logic [3:0] S_CMP0   = 4'd6;
    localparam logic [3:0] S_CMP1   = 4'd7;
    localparam logic [3:0] S_CEND   = 4'd8;
    localparam logic [3:0] S_EMIT   = 4'd9;
    localparam logic [3:0] S_CPY0   = 4'd10;
    localparam logic [3:0] S_CPY1   = 4'd11;

    logic [3:0]        r_st;
    logic [2:0]        r_phase;
    logic [PW-1:0]     r_loaded;
    logic [PW-1:0]     r_scan;
    logic [PW-1:0]     r_lit;
    logic [31:0]       r_tok;
    logic [2:0]        r_tok_cnt;
    logic [12:0]       r_copy_rem;
    logic [PW-1:0]     r_copy_src;
    logic              r_ovf;
    logic [LW-1:0]     r_mlen;
    logic [DIST_W-1:0] r_dist;
    logic [PW-1:0]     r_cand;
    logic [LW-1:0]     r_len;
    logic [LW-1:0]     r_kmax;
    logic [LW-1:0]     r_cnt;
    logic [HASH_W-1:0] r_h;
    logic [7:0]        r_b0;
    logic [7:0]        r_b1;
    logic              r_hvalid [HASH_ENTRIES];
    logic              r_hv_q;
    logic [AW-1:0]     r_head_q;
    logic [AW-1:0]     heads [HASH_ENTRIES];
    logic              r_ov;
    logic [7:0]        r_obyte;
    logic              r_ovalid;
    logic              r_olast;
    logic              r_oovf;

    logic              s_acc;
    logic              ld_ok;
    logic [PW-1:0]     eff_loaded;
    logic              st_we;
    logic [PW-1:0]     raddr_a;
    logic [PW-1:0]     raddr_b;
    logic [7:0]        rd_a;
    logic [7:0]        rd_b;
    logic [HASH_W-1:0] h_now;
    logic              hd_we;
    logic [HASH_W-1:0] hd_waddr;
    logic [PW-1:0]     hd;
    logic [PW-1:0]     cand_dist;
    logic              cand_ok;
    logic [PW-1:0]     ld_cs;
    logic [LW-1:0]     kmax;
    logic [PW-1:0]     rl;
    logic [PW-1:0]     jraw;
    logic              is_long;
    logic              is_short;
    logic [8:0]        jl;
    logic [3:0]        js;
    logic [8:0]        run_j;
    logic [31:0]       run_tok;
    logic [12:0]       run_copy;
    logic [1:0]        tail_j;
    logic [9:0]        l10;
    logic [9:0]        l3;
    logic [9:0]        l4;
    logic [2:0]        rl3;
    logic [31:0]       mt_tok;
    logic [2:0]        mt_cnt;

    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_st == S_IDLE) && (!r_ov || i_m_axis_tready);
    assign ld_ok           = (r_phase == PH_LOAD) || (r_phase == PH_DONE);
    assign eff_loaded      = (r_phase == PH_DONE) ? '0 : r_loaded;
    assign st_we           = s_acc && !i_s_axis_tuser[0] && ld_ok &&
                             (eff_loaded < PW'(BLOCK_BYTES));

    always_comb begin
        raddr_a = r_copy_src;
        raddr_b = r_scan;
        unique case (r_st)
            S_H0: begin
                raddr_a = r_scan;
                raddr_b = r_scan + PW'(1);
            end
            S_H1: begin
                raddr_a = r_scan + PW'(2);
                raddr_b = r_scan + PW'(3);
            end
            S_CMP0: begin
                raddr_a = r_scan + PW'(r_len);
                raddr_b = r_cand + PW'(r_len);
            end
            default: begin
                raddr_a = r_copy_src;
                raddr_b = r_scan;
            end
        endcase
    end

    lzc_store #(
        .DEPTH (BLOCK_BYTES),
        .PW    (PW)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (st_we),
        .i_waddr   (eff_loaded[AW-1:0]),
        .i_wdata   (i_s_axis_tdata),
        .i_limit   (r_loaded),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    assign h_now = lzc_hash({rd_b, rd_a, r_b1, r_b0});

    // scan candidate
    assign hd        = r_hv_q ? PW'(r_head_q) : '0;
    assign cand_dist = r_scan - hd;
    assign cand_ok   = (hd < r_scan) && (32'(cand_dist) <= MAX_DIST);
    assign ld_cs     = r_loaded - r_scan;
    assign kmax      = (32'(ld_cs) > MAX_MATCH) ? LW'(MAX_MATCH) : LW'(ld_cs);

    // hash head writes
    always_comb begin
        hd_we    = 1'b0;
        hd_waddr = r_h;
        if (r_st == S_H2 && r_phase == PH_LITS) begin
            hd_we    = 1'b1;
            hd_waddr = h_now;
        end else if ((r_st == S_HDQ && !cand_ok) ||
                     (r_st == S_CEND && r_len < LW'(MIN_MATCH))) begin
            hd_we    = 1'b1;
            hd_waddr = r_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hd_we) begin
            heads[hd_waddr] <= r_scan[AW-1:0];
        end
        r_head_q <= heads[h_now];
    end

    // literal run tokens
    assign rl       = (r_phase == PH_TAIL) ? (r_loaded - r_lit) : (r_scan - r_lit);
    assign jraw     = (rl >> 3) - PW'(1);
    assign is_long  = 32'(rl) > ((r_phase == PH_TAIL) ? 32'd131 : 32'd135);
    assign is_short = !is_long && (32'(rl) >= ((r_phase == PH_TAIL) ? 32'd9 : 32'd8));
    assign jl       = (32'(jraw) > 32'd511) ? 9'd511 : 9'(jraw);
    assign js       = (32'(jraw) > 32'd15) ? 4'd15 : 4'(jraw);
    assign run_j    = is_long ? jl : 9'(js);
    assign run_tok  = is_long ? (32'(TOK_LONG_RUN) + (32'(jl) << 7))
                              : (32'(TOK_SHORT_RUN) + (32'(js) << 4));
    assign run_copy = (13'(run_j) + 13'd1) << 3;
    assign tail_j   = (32'(rl) > 32'd3) ? 2'd3 : 2'(rl);

    // match token
    assign l10 = 10'(r_mlen);
    assign l3  = l10 - 10'd3;
    assign l4  = l10 - 10'd4;
    assign rl3 = rl[2:0];

    always_comb begin
        if (l10 <= 10'd10 && r_dist <= DIST_W'(511)) begin
            mt_tok = {16'd0, r_dist[8:0], l3[2:0], rl3, 1'b0};
            mt_cnt = 3'd2;
        end else if (l10 <= 10'd67 && r_dist <= DIST_W'(8191)) begin
            mt_tok = {8'd0, r_dist[12:0], l4[5:0], rl3, 2'b01};
            mt_cnt = 3'd3;
        end else begin
            mt_tok = {r_dist[16:0], l4[8:0], rl3, 3'b011};
            mt_cnt = 3'd4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hv_q <= r_hvalid[h_now];
        if (!i_rst_n) begin
            r_st       <= S_IDLE;
            r_phase    <= PH_LOAD;
            r_loaded   <= '0;
            r_scan     <= '0;
            r_lit      <= '0;
            r_tok_cnt  <= '0;
            r_copy_rem <= '0;
            r_ovf      <= 1'b0;
            r_ov       <= 1'b0;
            for (int i = 0; i < HASH_ENTRIES; i++) begin
                r_hvalid[i] <= 1'b0;
            end
        end else begin
            if (i_m_axis_tready) begin
                r_ov <= 1'b0;
            end
            if (hd_we) begin
                r_hvalid[hd_waddr] <= 1'b1;
            end
            unique case (r_st)
                S_IDLE: begin
                    if (s_acc && !i_s_axis_tuser[0]) begin
                        if (r_phase == PH_DONE) begin
                            for (int i = 0; i < HASH_ENTRIES; i++) begin
                                r_hvalid[i] <= 1'b0;
                            end
                            r_scan     <= '0;
                            r_lit      <= '0;
                            r_tok_cnt  <= '0;
                            r_copy_rem <= '0;
                            r_ovf      <= 1'b0;
                        end
                        if (ld_ok) begin
                            if (eff_loaded < PW'(BLOCK_BYTES)) begin
                                r_loaded <= eff_loaded + PW'(1);
                            end else begin
                                r_loaded <= eff_loaded;
                                r_ovf    <= 1'b1;
                            end
                            r_phase <= i_s_axis_tlast ? PH_SCAN : PH_LOAD;
                        end
                    end else if (s_acc) begin
                        if (ld_ok) begin
                            r_ov     <= 1'b1;
                            r_obyte  <= 8'd0;
                            r_ovalid <= 1'b0;
                            r_olast  <= 1'b0;
                            r_oovf   <= r_ovf;
                        end else begin
                            r_st <= S_REFILL;
                        end
                    end
                end
                S_REFILL: begin
                    if (r_tok_cnt != 3'd0 || r_copy_rem != 13'd0) begin
                        r_st <= S_EMIT;
                    end else begin
                        unique case (r_phase)
                            PH_SCAN: begin
                                if (r_scan >= r_loaded) begin
                                    r_phase <= PH_TAIL;
                                end else begin
                                    r_st <= S_H0;
                                end
                            end
                            PH_LITS: begin
                                if (is_long || is_short) begin
                                    r_tok      <= run_tok;
                                    r_tok_cnt  <= is_long ? 3'd2 : 3'd1;
                                    r_copy_src <= r_lit;
                                    r_copy_rem <= run_copy;
                                    r_lit      <= r_lit + PW'(run_copy);
                                end else begin
                                    r_tok      <= mt_tok;
                                    r_tok_cnt  <= mt_cnt;
                                    r_copy_src <= r_lit;
                                    r_copy_rem <= 13'(rl3);
                                    r_cnt      <= r_mlen;
                                    r_st       <= S_H0;
                                end
                            end
                            PH_TAIL: begin
                                if (is_long || is_short) begin
                                    r_tok      <= run_tok;
                                    r_tok_cnt  <= is_long ? 3'd2 : 3'd1;
                                    r_copy_src <= r_lit;
                                    r_copy_rem <= run_copy;
                                    r_lit      <= r_lit + PW'(run_copy);
                                end else if (rl != '0) begin
                                    r_tok      <= 32'(TOK_TAIL) + (32'(tail_j) << 6);
                                    r_tok_cnt  <= 3'd1;
                                    r_copy_src <= r_lit;
                                    r_copy_rem <= 13'(tail_j);
                                    r_lit      <= r_lit + PW'(tail_j);
                                end else begin
                                    r_tok     <= 32'(TOK_TAIL);
                                    r_tok_cnt <= 3'd1;
                                    r_phase   <= PH_TERM;
                                end
                            end
                            default: r_st <= S_EMIT;
                        endcase
                    end
                end
                S_H0: r_st <= S_H1;
                S_H1: begin
                    r_b0 <= rd_a;
                    r_b1 <= rd_b;
                    r_st <= S_H2;
                end
                S_H2: begin
                    r_h <= h_now;
                    if (r_phase == PH_SCAN) begin
                        r_st <= S_HDQ;
                    end else begin
                        r_scan <= r_scan + PW'(1);
                        r_cnt  <= r_cnt - LW'(1);
                        if (r_cnt == LW'(1)) begin
                            r_lit   <= r_scan + PW'(1);
                            r_phase <= PH_SCAN;
                            r_st    <= S_REFILL;
                        end else begin
                            r_st <= S_H0;
                        end
                    end
                end
                S_HDQ: begin
                    if (cand_ok) begin
                        r_cand <= hd;
                        r_len  <= '0;
                        r_kmax <= kmax;
                        r_dist <= DIST_W'(cand_dist);
                        r_st   <= S_CMP0;
                    end else begin
                        r_scan <= r_scan + PW'(1);
                        r_st   <= S_REFILL;
                    end
                end
                S_CMP0: r_st <= (r_len < r_kmax) ? S_CMP1 : S_CEND;
                S_CMP1: begin
                    if (rd_a == rd_b) begin
                        r_len <= r_len + LW'(1);
                        r_st  <= S_CMP0;
                    end else begin
                        r_st <= S_CEND;
                    end
                end
                S_CEND: begin
                    if (r_len < LW'(MIN_MATCH)) begin
                        r_scan <= r_scan + PW'(1);
                    end else begin
                        r_mlen  <= r_len;
                        r_phase <= PH_LITS;
                    end
                    r_st <= S_REFILL;
                end
                S_EMIT: begin
                    if (r_tok_cnt != 3'd0) begin
                        r_ov      <= 1'b1;
                        r_obyte   <= r_tok[7:0];
                        r_ovalid  <= 1'b1;
                        r_oovf    <= r_ovf;
                        r_tok     <= r_tok >> 8;
                        r_tok_cnt <= r_tok_cnt - 3'd1;
                        r_olast   <= 1'b0;
                        if (r_phase == PH_TERM && r_tok_cnt == 3'd1 &&
                            r_copy_rem == 13'd0) begin
                            r_olast <= 1'b1;
                            r_phase <= PH_DONE;
                        end
                        r_st <= S_IDLE;
                    end else if (r_copy_rem != 13'd0) begin
                        r_st <= S_CPY0;
                    end else begin
                        r_ov     <= 1'b1;
                        r_obyte  <= 8'd0;
                        r_ovalid <= 1'b0;
                        r_olast  <= 1'b0;
                        r_oovf   <= r_ovf;
                        r_st     <= S_IDLE;
                    end
                end
                S_CPY0: r_st <= S_CPY1;
                S_CPY1: begin
                    r_ov       <= 1'b1;
                    r_obyte    <= rd_a;
                    r_ovalid   <= 1'b1;
                    r_oovf     <= r_ovf;
                    r_copy_src <= r_copy_src + PW'(1);
                    r_copy_rem <= r_copy_rem - 13'd1;
                    r_olast    <= 1'b0;
                    if (r_phase == PH_TERM && r_copy_rem == 13'd1) begin
                        r_olast <= 1'b1;
                        r_phase <= PH_DONE;
                    end
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_obyte;
    assign o_m_axis_tlast  = r_olast;
    assign o_m_axis_tuser  = {r_oovf, r_ovalid};

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_LOAD && r_phase != PH_DONE) |->
        (r_lit <= r_loaded && r_scan <= r_loaded))
        else $error("scan or literal position past block end");

    a_cmp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_CMP1) |-> (r_len < r_kmax))
        else $error("match compare beyond limit");

    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_olast) |-> (r_ovalid && r_obyte == TOK_TAIL && r_phase == PH_DONE))
        else $error("end beat malformed");

endmodule
